@@ hw/rtl/ttrg_pkg.sv @@
// ----------------------------------------------------------------------------
// ttrg_pkg: shared types and constants for the rotation gesture core
// Job format between the front and back parts, phase codes, arctan table.
// ----------------------------------------------------------------------------
`default_nettype none

package ttrg_pkg;

   localparam int CoordW = 16;
   localparam int TimeW  = 32;
   localparam int AngW   = 16;
   localparam int CenW   = 17;
   localparam int XyW    = 28;
   localparam int ZW     = 21;

   localparam logic [2:0] PH_UP          = 3'd1;
   localparam logic [2:0] PH_INTERRUPTED = 3'd4;

   localparam logic [1:0] RES_STARTED    = 2'd0;
   localparam logic [1:0] RES_CONTINUING = 2'd1;
   localparam logic [1:0] RES_FINISHED   = 2'd2;
   localparam logic [1:0] RES_CANCELLED  = 2'd3;

   localparam logic       CMD_CANCEL = 1'b1;
   localparam logic       CSR_MIN_EVENTS       = 1'b0;
   localparam logic       CSR_MIN_EVENTS_AFTER = 1'b1;

   localparam logic signed [ZW-1:0]  PI_Q16 = 21'sd205887;
   localparam logic signed [AngW-1:0] PI_Q12 = 16'sd12868;

   typedef enum logic [2:0] {
      MODE_CLEAR    = 3'b001,
      MODE_POSSIBLE = 3'b010,
      MODE_STARTED  = 3'b100
   } mode_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_ROT  = 3'b010,
      BK_DONE = 3'b100
   } back_state_type;

   typedef enum logic {
      JOB_CAPTURE = 1'b0,
      JOB_REPORT  = 1'b1
   } job_kind_type;

   typedef enum logic [1:0] {
      START_KEEP  = 2'd0,
      START_FIRST = 2'd1,
      START_CUR   = 2'd2
   } start_sel_type;

   typedef struct packed {
      job_kind_type            kind;
      start_sel_type           start_sel;
      logic [1:0]              phase;
      logic                    geo;
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
      logic signed [CoordW-1:0] x2;
      logic signed [CoordW-1:0] y2;
      logic [TimeW-1:0]        t;
   } job_type;

   // atan(2^-i) in Q4.16 (21-bit signed), rounded to nearest.
   function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      begin
         unique case (i)
            5'd0:  v = 21'sd51472;
            5'd1:  v = 21'sd30386;
            5'd2:  v = 21'sd16055;
            5'd3:  v = 21'sd8150;
            5'd4:  v = 21'sd4091;
            5'd5:  v = 21'sd2047;
            5'd6:  v = 21'sd1024;
            5'd7:  v = 21'sd512;
            5'd8:  v = 21'sd256;
            5'd9:  v = 21'sd128;
            5'd10: v = 21'sd64;
            5'd11: v = 21'sd32;
            5'd12: v = 21'sd16;
            5'd13: v = 21'sd8;
            5'd14: v = 21'sd4;
            5'd15: v = 21'sd2;
            5'd16: v = 21'sd1;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/two_touch_rotation_gesture_core.sv @@
// ----------------------------------------------------------------------------
// two_touch_rotation_gesture_core: two-finger rotation gesture recognizer
// Classifies touch beats, measures the finger angle and reports gestures.
// ----------------------------------------------------------------------------
// Usage. Touch and cancel beats enter on the req_ queue port: a beat is taken
// when req_push is high and req_full is low. Results leave on the rsp_ queue
// port: the oldest result sits on the rsp_ fields while rsp_empty is low and
// is taken when rsp_pop is high. The two thresholds are written through the
// csr_ port while the core is idle.
// The front part classifies each beat in the cycle it arrives and places at
// most one job in a four-entry queue. The back part runs an iterative CORDIC
// arctangent, one rotation per cycle, and takes a new job only when the last
// is done, so that unit sets the sustained rate. With the back part idle, a
// beat's job goes via the queue and the rotations into the result register.
// Reset clears the gesture to the clear state, the thresholds to four and
// empties the queue and result register. If the receiver stalls, the result
// register holds, the back part waits, the queue fills and req_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module two_touch_rotation_gesture_core
   import ttrg_pkg::*;
#(
   parameter int CORDIC_STEPS = 14
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_command,
   input  wire logic [3:0]        req_point_count,
   input  wire logic signed [15:0] req_first_x,
   input  wire logic signed [15:0] req_first_y,
   input  wire logic signed [15:0] req_second_x,
   input  wire logic signed [15:0] req_second_y,
   input  wire logic [2:0]        req_first_phase,
   input  wire logic [2:0]        req_second_phase,
   input  wire logic [31:0]       req_event_time,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [1:0]             rsp_gesture_phase,
   output logic signed [15:0]     rsp_rotation,
   output logic signed [16:0]     rsp_center_x2,
   output logic signed [16:0]     rsp_center_y2,
   output logic [31:0]            rsp_report_time,
   output logic                   rsp_has_geometry
);

   logic    accept, job_valid, q_empty, q_pop;
   job_type job, q_job;

   // A beat is taken only when the queue has room for the job it may make.
   assign accept = req_push && !req_full;

   ttrg_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_wdata,
      .accept,
      .command      (req_command),
      .point_count  (req_point_count),
      .first_x      (req_first_x),
      .first_y      (req_first_y),
      .second_x     (req_second_x),
      .second_y     (req_second_y),
      .first_phase  (req_first_phase),
      .second_phase (req_second_phase),
      .event_time   (req_event_time),
      .job_valid,
      .job
   );

   ttrg_queue u_queue (
      .clock, .reset,
      .wr_en  (accept && job_valid),
      .wr_job (job),
      .full   (req_full),
      .rd_en  (q_pop),
      .rd_job (q_job),
      .empty  (q_empty)
   );

   ttrg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .q_empty, .q_job, .q_pop,
      .rsp_empty, .rsp_pop, .rsp_gesture_phase, .rsp_rotation,
      .rsp_center_x2, .rsp_center_y2, .rsp_report_time, .rsp_has_geometry
   );

endmodule

`default_nettype wire

@@ hw/rtl/ttrg_queue.sv @@
// ----------------------------------------------------------------------------
// ttrg_queue: job queue between front and back
// Four-entry first-in first-out buffer of decoded jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module ttrg_queue
   import ttrg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_job,
   output logic         full,
   input  wire logic    rd_en,
   output job_type      rd_job,
   output logic         empty
);

   job_type    mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;

   assign full   = (cnt_ff == 3'd4);
   assign empty  = (cnt_ff == 3'd0);
   assign rd_job = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + 2'd1;
      rp_in  = rp_ff + 2'd1;
      cnt_in = cnt_ff + {2'b0, wr_en} - {2'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_in;
         if (rd_en) rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ttrg_front.sv @@
// ----------------------------------------------------------------------------
// ttrg_front: gesture state machine
// Accepts events, tracks the buffered count and last event, issues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module ttrg_front
   import ttrg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              accept,
   input  wire logic              command,
   input  wire logic [3:0]        point_count,
   input  wire logic signed [CoordW-1:0] first_x,
   input  wire logic signed [CoordW-1:0] first_y,
   input  wire logic signed [CoordW-1:0] second_x,
   input  wire logic signed [CoordW-1:0] second_y,
   input  wire logic [2:0]        first_phase,
   input  wire logic [2:0]        second_phase,
   input  wire logic [TimeW-1:0]  event_time,
   output logic                   job_valid,
   output job_type                job
);

   logic [7:0]  min_ev_ff, min_after_ff;
   mode_type    mode_ff, mode_in;
   logic [7:0]  held_ff, held_in, held_inc;
   logic signed [CoordW-1:0] lx1_ff, ly1_ff, lx2_ff, ly2_ff;
   logic [TimeW-1:0] lt_ff;
   logic        store;
   logic        two, any_up;

   always_comb begin
      held_inc  = (held_ff == 8'hFF) ? held_ff : held_ff + 8'd1;
      two       = (point_count == 4'd2);
      any_up    = (first_phase == PH_UP) || (second_phase == PH_UP);
      mode_in   = mode_ff;
      held_in   = held_ff;
      store     = 1'b0;
      job_valid = 1'b0;
      job.kind      = JOB_REPORT;
      job.start_sel = START_KEEP;
      job.phase     = RES_CANCELLED;
      job.geo       = 1'b1;
      job.x1        = first_x;
      job.y1        = first_y;
      job.x2        = second_x;
      job.y2        = second_y;
      job.t         = event_time;
      if (command == CMD_CANCEL) begin
         if (mode_ff != MODE_CLEAR && held_ff != 8'd0) begin
            job_valid = 1'b1;
            job.x1 = lx1_ff; job.y1 = ly1_ff; job.x2 = lx2_ff; job.y2 = ly2_ff;
            job.t  = lt_ff;
            mode_in = MODE_CLEAR;
            held_in = '0;
         end
      end else begin
         unique case (mode_ff)
            MODE_CLEAR: begin
               if (two) begin
                  mode_in   = MODE_POSSIBLE;
                  held_in   = 8'd1;
                  store     = 1'b1;
                  job_valid = 1'b1;
                  job.kind  = JOB_CAPTURE;
               end
            end
            MODE_POSSIBLE: begin
               if (!two || any_up || first_phase == PH_INTERRUPTED) begin
                  mode_in = MODE_CLEAR;
                  held_in = '0;
               end else begin
                  store   = 1'b1;
                  held_in = held_inc;
                  if (held_inc >= min_ev_ff) begin
                     held_in = '0;
                     if (min_ev_ff == 8'd0) begin
                        mode_in = MODE_CLEAR;
                     end else begin
                        mode_in       = MODE_STARTED;
                        job_valid     = 1'b1;
                        job.phase     = RES_STARTED;
                        job.start_sel = (min_ev_ff == 8'd1) ? START_CUR : START_FIRST;
                     end
                  end
               end
            end
            default: begin
               if (first_phase == PH_INTERRUPTED) begin
                  job_valid = 1'b1;
                  job.geo   = 1'b0;
                  mode_in   = MODE_CLEAR;
                  held_in   = '0;
               end else if (!two) begin
                  job_valid = 1'b1;
                  if (held_ff != 8'd0) begin
                     job.phase = RES_FINISHED;
                     job.x1 = lx1_ff; job.y1 = ly1_ff; job.x2 = lx2_ff; job.y2 = ly2_ff;
                  end else begin
                     job.geo = 1'b0;
                  end
                  mode_in = MODE_CLEAR;
                  held_in = '0;
               end else begin
                  store   = 1'b1;
                  held_in = held_inc;
                  if (any_up) begin
                     job_valid = 1'b1;
                     job.phase = RES_FINISHED;
                     mode_in   = MODE_CLEAR;
                     held_in   = '0;
                  end else if (held_inc >= min_after_ff) begin
                     job_valid = 1'b1;
                     job.phase = RES_CONTINUING;
                     held_in   = '0;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store) begin
         lx1_ff <= first_x;
         ly1_ff <= first_y;
         lx2_ff <= second_x;
         ly2_ff <= second_y;
         lt_ff  <= event_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ev_ff    <= 8'd4;
         min_after_ff <= 8'd4;
         mode_ff      <= MODE_CLEAR;
         held_ff      <= '0;
      end else begin
         if (csr_write && csr_index == CSR_MIN_EVENTS) min_ev_ff <= csr_wdata;
         if (csr_write && csr_index == CSR_MIN_EVENTS_AFTER) min_after_ff <= csr_wdata;
         if (accept) begin
            mode_ff <= mode_in;
            held_ff <= held_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ttrg_back.sv @@
// ----------------------------------------------------------------------------
// ttrg_back: angle unit and result register
// Iterative CORDIC arctangent, start-angle bookkeeping and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ttrg_back
   import ttrg_pkg::*;
#(
   parameter int CORDIC_STEPS = 14
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_empty,
   input  wire job_type   q_job,
   output logic           q_pop,
   output logic           rsp_empty,
   input  wire logic      rsp_pop,
   output logic [1:0]     rsp_gesture_phase,
   output logic signed [AngW-1:0] rsp_rotation,
   output logic signed [CenW-1:0] rsp_center_x2,
   output logic signed [CenW-1:0] rsp_center_y2,
   output logic [TimeW-1:0] rsp_report_time,
   output logic           rsp_has_geometry
);

   localparam int StepW = $clog2(CORDIC_STEPS + 1);

   back_state_type state_ff, state_in;
   job_type    job_ff;
   logic signed [XyW-1:0] x_ff, y_ff, x_in, y_in, lx, ly, sx, sy;
   logic signed [ZW-1:0]  z_ff, z_in, lz, zr;
   logic [StepW-1:0] step_ff;
   logic       zero_ff;
   logic signed [AngW-1:0] first_ff, start_ff, r_ang;
   logic       out_valid_ff, out_load;

   always_comb begin
      lx = (XyW'(q_job.x2) - XyW'(q_job.x1)) <<< 8;
      ly = (XyW'(q_job.y2) - XyW'(q_job.y1)) <<< 8;
      lz = '0;
      if (lx < 0) begin
         lz = (ly >= 0) ? PI_Q16 : -PI_Q16;
         lx = -lx;
         ly = -ly;
      end
      sx = x_ff >>> step_ff;
      sy = y_ff >>> step_ff;
      if (y_ff > 0) begin
         x_in = x_ff + sy;
         y_in = y_ff - sx;
         z_in = z_ff + atan_q16(5'(step_ff));
      end else begin
         x_in = x_ff - sy;
         y_in = y_ff + sx;
         z_in = z_ff - atan_q16(5'(step_ff));
      end
      zr = (z_ff + 21'sd8) >>> 4;
      if (zero_ff) r_ang = '0;
      else if (zr > ZW'(PI_Q12)) r_ang = PI_Q12;
      else if (zr < -ZW'(PI_Q12)) r_ang = -PI_Q12;
      else r_ang = zr[AngW-1:0];
   end

   assign out_load = (state_ff == BK_DONE) && (job_ff.kind == JOB_REPORT)
                     && (!out_valid_ff || rsp_pop);
   assign q_pop     = (state_ff == BK_IDLE) && !q_empty;
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!q_empty) state_in = BK_ROT;
         BK_ROT:  if (step_ff == StepW'(CORDIC_STEPS - 1)) state_in = BK_DONE;
         BK_DONE: if (job_ff.kind == JOB_CAPTURE || out_load) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff  <= q_job;
         x_ff    <= lx;
         y_ff    <= ly;
         z_ff    <= lz;
         step_ff <= '0;
         zero_ff <= (q_job.x2 == q_job.x1) && (q_job.y2 == q_job.y1);
      end else if (state_ff == BK_ROT) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         step_ff <= step_ff + 1'b1;
      end
      if (out_load) begin
         rsp_gesture_phase <= job_ff.phase;
         rsp_report_time   <= job_ff.t;
         rsp_has_geometry  <= job_ff.geo;
         if (job_ff.geo) begin
            unique case (job_ff.start_sel)
               START_FIRST: rsp_rotation <= r_ang - first_ff;
               START_CUR:   rsp_rotation <= '0;
               default:     rsp_rotation <= r_ang - start_ff;
            endcase
            rsp_center_x2 <= CenW'(job_ff.x1) + CenW'(job_ff.x2);
            rsp_center_y2 <= CenW'(job_ff.y1) + CenW'(job_ff.y2);
         end else begin
            rsp_rotation  <= '0;
            rsp_center_x2 <= '0;
            rsp_center_y2 <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         first_ff     <= '0;
         start_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
         if (state_ff == BK_DONE && job_ff.kind == JOB_CAPTURE) first_ff <= r_ang;
         if (out_load && job_ff.start_sel == START_FIRST) start_ff <= first_ff;
         if (out_load && job_ff.start_sel == START_CUR) start_ff <= r_ang;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_two_touch_rotation_gesture_core.sv @@
// ----------------------------------------------------------------------------
// tb_two_touch_rotation_gesture_core: self-checking bench for the gesture core
// Sends directed and random touch and cancel beats through the request queue,
// predicts each gesture report with a bit-true model of the recognizer and
// CORDIC arctangent, and compares every popped report field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_touch_rotation_gesture_core;
   import ttrg_pkg::*;

   localparam int CycleLimit = 600000;
   localparam int Steps      = 14;

   typedef struct {
      logic              cmd;
      logic [3:0]        pc;
      logic signed [15:0] x1, y1, x2, y2;
      logic [2:0]        p1, p2;
      logic [31:0]       t;
   } touch_type;

   typedef struct {
      logic [1:0]         phase;
      logic signed [15:0] rot;
      logic signed [16:0] cx, cy;
      logic [31:0]        t;
      logic               geo;
   } report_type;

   logic clock, reset;
   logic csr_write, csr_index;
   logic [7:0] csr_wdata;
   logic req_push, req_full, req_command;
   logic [3:0] req_point_count;
   logic signed [15:0] req_first_x, req_first_y, req_second_x, req_second_y;
   logic [2:0] req_first_phase, req_second_phase;
   logic [31:0] req_event_time;
   logic rsp_empty, rsp_pop;
   logic [1:0] rsp_gesture_phase;
   logic signed [15:0] rsp_rotation;
   logic signed [16:0] rsp_center_x2, rsp_center_y2;
   logic [31:0] rsp_report_time;
   logic rsp_has_geometry;

   two_touch_rotation_gesture_core #(.CORDIC_STEPS(Steps)) dut (.*);

   // Gesture model state, mirrored from the recognizer.
   int unsigned min_ev, min_ev_after;
   mode_type    g_mode;
   int unsigned held;
   int          start_ang, first_ang;
   int          last_c[4];
   logic [31:0] last_t;

   report_type  pending_reports[$];
   int          fail_count;
   int          cycle_count;
   int          beats_sent;
   int          hold_cycles;
   bit          calm;

   // Arctangent of 2^-i in Q15.16.
   int atan_tab[20] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                        64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Global watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Finger bearing in Q3.12 radians. Arithmetic right shifts floor, as the
   // hardware does.
   function automatic int bearing(int x1, int y1, int x2, int y2);
      int x, y, z, nx, r;
      x = (x2 - x1) * 256;
      y = (y2 - y1) * 256;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 205887 : -205887;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < Steps && i < 20; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += atan_tab[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= atan_tab[i];
         end
         x = nx;
      end
      r = (z + 8) >>> 4;
      if (r > 12868) r = 12868;
      if (r < -12868) r = -12868;
      return r;
   endfunction

   function automatic report_type make_report(logic [1:0] ph, bit geo, int c[4],
                                              logic [31:0] t);
      report_type r;
      r.phase = ph;
      r.t     = t;
      r.geo   = geo;
      r.rot   = geo ? 16'(bearing(c[0], c[1], c[2], c[3]) - start_ang) : '0;
      r.cx    = geo ? 17'(c[0] + c[2]) : '0;
      r.cy    = geo ? 17'(c[1] + c[3]) : '0;
      return r;
   endfunction

   // Appends a predicted report behind the ones already waiting.
   function automatic void queue_report(report_type r);
      pending_reports.insert(pending_reports.size(), r);
   endfunction

   function automatic void buffer_event(int c[4], logic [31:0] t);
      last_c = c;
      last_t = t;
      if (held < 255) held++;
   endfunction

   // Advances the gesture state by one accepted beat and queues any report.
   function automatic void advance_gesture(touch_type b);
      int c[4];
      int cur;
      c = '{int'(b.x1), int'(b.y1), int'(b.x2), int'(b.y2)};
      if (b.cmd == CMD_CANCEL) begin
         if (g_mode != MODE_CLEAR && held > 0) begin
            queue_report(make_report(RES_CANCELLED, 1, last_c, last_t));
            g_mode = MODE_CLEAR;
            held = 0;
         end
         return;
      end
      if (g_mode == MODE_CLEAR) begin
         if (b.pc == 2) begin
            g_mode = MODE_POSSIBLE;
            held = 0;
            buffer_event(c, b.t);
            first_ang = bearing(c[0], c[1], c[2], c[3]);
         end
         return;
      end
      if (g_mode == MODE_POSSIBLE) begin
         if (b.pc != 2 || b.p1 == PH_UP || b.p2 == PH_UP || b.p1 == PH_INTERRUPTED) begin
            g_mode = MODE_CLEAR;
            held = 0;
            return;
         end
         buffer_event(c, b.t);
         if (held < min_ev) return;
         held = 0;
         if (min_ev == 0) begin
            g_mode = MODE_CLEAR;
            return;
         end
         cur = bearing(c[0], c[1], c[2], c[3]);
         start_ang = (min_ev == 1) ? cur : first_ang;
         queue_report(make_report(RES_STARTED, 1, c, b.t));
         g_mode = MODE_STARTED;
         return;
      end
      if (b.p1 == PH_INTERRUPTED) begin
         queue_report(make_report(RES_CANCELLED, 0, c, b.t));
         g_mode = MODE_CLEAR;
         held = 0;
         return;
      end
      if (b.pc != 2) begin
         if (held > 0)
            queue_report(make_report(RES_FINISHED, 1, last_c, b.t));
         else
            queue_report(make_report(RES_CANCELLED, 0, c, b.t));
         g_mode = MODE_CLEAR;
         held = 0;
         return;
      end
      buffer_event(c, b.t);
      if (b.p1 == PH_UP || b.p2 == PH_UP) begin
         queue_report(make_report(RES_FINISHED, 1, c, b.t));
         g_mode = MODE_CLEAR;
         held = 0;
      end else if (held >= min_ev_after) begin
         queue_report(make_report(RES_CONTINUING, 1, c, b.t));
         held = 0;
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0d] mismatch: %s", cycle_count, what);
      fail_count++;
   endtask

   // Result checker: every popped report is matched to the oldest prediction.
   always @(posedge clock) begin
      report_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("report with no prediction waiting");
         end else begin
            e = pending_reports.pop_front();
            if (rsp_gesture_phase !== e.phase)
               report_mismatch($sformatf("phase %0d, want %0d", rsp_gesture_phase, e.phase));
            if (rsp_rotation !== e.rot)
               report_mismatch($sformatf("rotation %0d, want %0d", rsp_rotation, e.rot));
            if (rsp_center_x2 !== e.cx)
               report_mismatch($sformatf("center_x2 %0d, want %0d", rsp_center_x2, e.cx));
            if (rsp_center_y2 !== e.cy)
               report_mismatch($sformatf("center_y2 %0d, want %0d", rsp_center_y2, e.cy));
            if (rsp_report_time !== e.t)
               report_mismatch($sformatf("time %h, want %h", rsp_report_time, e.t));
            if (rsp_has_geometry !== e.geo)
               report_mismatch($sformatf("geometry %b, want %b", rsp_has_geometry, e.geo));
         end
      end
   end

   // Receiver: a random stall before each pop, plus an optional long hold-off
   // that lets the internal queue fill and push back on the sender.
   initial begin
      int gap;
      rsp_pop <= 1'b0;
      @(negedge reset);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 3);
         if (hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   // Sends one beat; push stays high across back-to-back beats.
   task automatic send_beat(touch_type b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_command      <= b.cmd;
      req_point_count  <= b.pc;
      req_first_x      <= b.x1;
      req_first_y      <= b.y1;
      req_second_x     <= b.x2;
      req_second_y     <= b.y2;
      req_first_phase  <= b.p1;
      req_second_phase <= b.p2;
      req_event_time   <= b.t;
      do @(posedge clock); while (req_full);
      advance_gesture(b);
      beats_sent++;
   endtask

   task automatic drain_reports();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      // Capture jobs make no report but still occupy the CORDIC unit.
      repeat (100) @(posedge clock);
   endtask

   task automatic write_threshold(logic idx, logic [7:0] val);
      drain_reports();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MIN_EVENTS) min_ev = val;
      else min_ev_after = val;
   endtask

   function automatic touch_type touch(logic [3:0] pc, logic [2:0] p1, logic [2:0] p2,
                                       int x1, int y1, int x2, int y2);
      touch_type b;
      b.cmd = 1'b0;
      b.pc  = pc;
      b.p1  = p1;
      b.p2  = p2;
      b.x1  = 16'(x1);
      b.y1  = 16'(y1);
      b.x2  = 16'(x2);
      b.y2  = 16'(y2);
      b.t   = $urandom;
      return b;
   endfunction

   function automatic touch_type noise_beat();
      touch_type b;
      b = touch(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
      b.cmd = $urandom_range(0, 3) == 0;
      return b;
   endfunction

   // One well-formed two-finger gesture with a random ending.
   task automatic run_gesture(int moves);
      int cx, cy, dx, dy, span;
      bit wide;
      touch_type b;
      wide = $urandom_range(0, 7) == 0;
      span = wide ? 32767 : $urandom_range(1, 2000);
      cx = wide ? 0 : $urandom_range(0, 40000) - 20000;
      cy = wide ? 0 : $urandom_range(0, 40000) - 20000;
      dx = $urandom_range(0, 2 * span) - span;
      dy = $urandom_range(0, 2 * span) - span;
      send_beat(touch(2, 0, 0, cx - dx / 2, cy - dy / 2, cx + dx / 2, cy + dy / 2));
      for (int i = 0; i < moves; i++) begin
         dx += $urandom_range(0, 200) - 100;
         dy += $urandom_range(0, 200) - 100;
         send_beat(touch(2, $urandom_range(0, 1) ? 2 : 3, $urandom_range(0, 1) ? 2 : 3,
                         cx - dx / 2, cy - dy / 2, cx + dx / 2, cy + dy / 2));
      end
      case ($urandom_range(0, 5))
         0: send_beat(touch(2, 2, 1, cx - dx / 2, cy - dy / 2, cx + dx / 2, cy + dy / 2));
         1: send_beat(touch(2, 1, 2, cx - dx / 2, cy - dy / 2, cx + dx / 2, cy + dy / 2));
         2: send_beat(touch($urandom_range(0, 1) ? 1 : 3, 2, 2, cx, cy, cx, cy));
         3: send_beat(touch(2, PH_INTERRUPTED, 2, cx, cy, cx + 1, cy));
         4: begin
            b = noise_beat();
            b.cmd = CMD_CANCEL;
            send_beat(b);
         end
         default: ;
      endcase
   endtask

   // Directed: extremes, every report kind and the named corner cases at the
   // default thresholds of four.
   task automatic test_directed();
      touch_type b;
      // Clear mode ignores a cancel and single-finger beats.
      b = noise_beat();
      b.cmd = CMD_CANCEL;
      send_beat(b);
      send_beat(touch(1, 0, 0, 5, 5, 0, 0));
      // Start, then finish by lifting the second finger.
      send_beat(touch(2, 0, 0, -32768, -32768, 32767, 32767));
      send_beat(touch(2, 2, 2, -32768, 32767, 32767, -32768));
      send_beat(touch(2, 3, 3, 32767, -32768, -32768, 32767));
      send_beat(touch(2, 2, 2, 0, 0, 0, 0));           // zero vector
      send_beat(touch(2, 2, 2, 100, 0, -100, 0));
      send_beat(touch(2, 2, 1, 100, 0, -100, 1));
      // Start, continuing report, then a three-point beat with an empty
      // buffer is cancelled without geometry.
      for (int i = 0; i < 4; i++) send_beat(touch(2, 2, 2, 0, 0, 10, i - 2));
      for (int i = 0; i < 4; i++) send_beat(touch(2, 2, 2, 0, 0, -10, i - 2));
      send_beat(touch(3, 2, 2, 1, 1, 1, 1));
      // Start, then point count change with events held gives finished.
      for (int i = 0; i < 5; i++) send_beat(touch(2, 2, 2, 0, 0, -5, -i));
      send_beat(touch(0, 2, 2, 0, 0, 0, 0));
      // Cancel while only possible is reported against the current start.
      send_beat(touch(2, 0, 0, 7, 7, 7, 9));
      b = noise_beat();
      b.cmd = CMD_CANCEL;
      send_beat(b);
      // Interrupt while started.
      for (int i = 0; i < 4; i++) send_beat(touch(2, 2, 2, 0, 0, 3, 3));
      send_beat(touch(2, PH_INTERRUPTED, 7, 0, 0, 3, 3));
      drain_reports();
   endtask

   // Thresholds at their extremes, including zero and the case where the
   // start count is lowered mid-gesture.
   task automatic test_thresholds();
      write_threshold(CSR_MIN_EVENTS, 8'd1);
      write_threshold(CSR_MIN_EVENTS_AFTER, 8'd1);
      for (int i = 0; i < 6; i++) run_gesture($urandom_range(0, 6));
      write_threshold(CSR_MIN_EVENTS, 8'd0);
      for (int i = 0; i < 4; i++) run_gesture($urandom_range(0, 4));
      write_threshold(CSR_MIN_EVENTS, 8'd255);
      write_threshold(CSR_MIN_EVENTS_AFTER, 8'd255);
      run_gesture(300);
      // Lowered while buffering: a possible gesture is held across the write.
      write_threshold(CSR_MIN_EVENTS, 8'd200);
      send_beat(touch(2, 0, 0, 0, 0, 30, 40));
      send_beat(touch(2, 2, 2, 0, 0, 40, 30));
      write_threshold(CSR_MIN_EVENTS, 8'd2);
      write_threshold(CSR_MIN_EVENTS_AFTER, 8'd2);
      send_beat(touch(2, 2, 2, 0, 0, -40, 30));
      for (int i = 0; i < 4; i++) send_beat(touch(2, 2, 2, 0, 0, -40, 30 + i));
      drain_reports();
   endtask

   // Long receiver hold-off while the sender keeps offering beats.
   task automatic test_backpressure();
      write_threshold(CSR_MIN_EVENTS, 8'd1);
      write_threshold(CSR_MIN_EVENTS_AFTER, 8'd1);
      hold_cycles = 400;
      calm = 1;
      run_gesture(40);
      calm = 0;
      drain_reports();
   endtask

   // Bulk random traffic across several threshold settings.
   task automatic test_random();
      logic [7:0] settings[6] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd16};
      int target;
      target = beats_sent + 1525;
      while (beats_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            write_threshold(CSR_MIN_EVENTS, settings[$urandom_range(0, 5)]);
            write_threshold(CSR_MIN_EVENTS_AFTER, settings[$urandom_range(0, 5)]);
            calm = $urandom_range(0, 3) == 0;
         end
         if ($urandom_range(0, 4) == 0)
            for (int i = 0; i < 3; i++) send_beat(noise_beat());
         else
            run_gesture($urandom_range(0, 12));
      end
      calm = 0;
   endtask

   initial begin
      fail_count   = 0;
      cycle_count  = 0;
      beats_sent   = 0;
      hold_cycles  = 0;
      calm         = 0;
      min_ev       = 4;
      min_ev_after = 4;
      g_mode       = MODE_CLEAR;
      held         = 0;
      start_ang    = 0;
      first_ang    = 0;
      last_c       = '{0, 0, 0, 0};
      last_t       = '0;
      reset            <= 1'b1;
      csr_write        <= 1'b0;
      csr_index        <= CSR_MIN_EVENTS;
      csr_wdata        <= '0;
      req_push         <= 1'b0;
      req_command      <= 1'b0;
      req_point_count  <= '0;
      req_first_x      <= '0;
      req_first_y      <= '0;
      req_second_x     <= '0;
      req_second_y     <= '0;
      req_first_phase  <= '0;
      req_second_phase <= '0;
      req_event_time   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_thresholds();
      test_backpressure();
      test_random();

      drain_reports();
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
